// File: rtl/lcs_pkg.sv
// shared types, sizes and command codes of the lcs row buffer
package lcs_pkg;

	localparam int MAX_LEN     = 64;
	localparam int SYMBOL_BITS = 8;

	localparam int CMD_W  = 2;
	localparam int IN_W   = 8;
	localparam int LEN_W  = 7;
	localparam int LEN_MAX = 127;
	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int SCORE_W = CNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_CLEAR  = 2'd3
	} command_t;

	// query beat travelling along the row
	typedef struct packed {
		logic                   valid;
		logic [SYMBOL_BITS-1:0] sym;
		logic [SCORE_W-1:0]     left;
		logic [SCORE_W-1:0]     diag;
	} wave_t;

	// per-column control from the top level
	typedef struct packed {
		logic                   active;
		logic                   load;
		logic                   clear;
		logic [SYMBOL_BITS-1:0] sym;
	} cell_ctrl_t;

endpackage

// File: rtl/lcs_cell.sv
// one column of the lcs score row: stored reference symbol and current score
module lcs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lcs_pkg::cell_ctrl_t ctrl,
	input  lcs_pkg::wave_t     wave_in,
	output lcs_pkg::wave_t     wave_out,
	output logic [lcs_pkg::SCORE_W-1:0] score
);
	import lcs_pkg::*;

	logic [SYMBOL_BITS-1:0] ref_q;
	logic [SCORE_W-1:0]     score_q;
	logic [SCORE_W-1:0]     next_score;
	logic                   hit;
	logic                   valid_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [SCORE_W-1:0]     left_q;
	logic [SCORE_W-1:0]     diag_q;

	always_comb begin
		hit = (ref_q == wave_in.sym);
		if (hit) begin
			next_score = wave_in.diag + SCORE_W'(1);
		end else if (score_q > wave_in.left) begin
			next_score = score_q;
		end else begin
			next_score = wave_in.left;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ref_q <= ctrl.sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (ctrl.clear || ctrl.load) begin
			score_q <= '0;
		end else if (wave_in.valid && ctrl.active) begin
			score_q <= next_score;
		end
	end

	// beat moves on to the next column; dies past the last stored symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= wave_in.valid && ctrl.active;
		end
	end

	always_ff @(posedge clk) begin
		sym_q  <= wave_in.sym;
		left_q <= next_score;
		diag_q <= score_q;
	end

	assign wave_out.valid = valid_q;
	assign wave_out.sym   = sym_q;
	assign wave_out.left  = left_q;
	assign wave_out.diag  = diag_q;
	assign score          = score_q;

endmodule

// File: rtl/lcs_length_row_buffer.sv
// top level of the lcs length engine: command intake, column control, result
//
// Command channel: a beat (command, symbol) is taken at a rising edge where
// start is high and busy is low. Query beats enter the row straight away,
// one per cycle while busy is low, and ripple one column per cycle along it.
// Append, finish and clear beats are held (busy high) until no query beat
// is left in the row, then run; on an idle row busy is high for one cycle,
// after a query stream until the row has drained.
// Result channel: done is high for exactly one cycle, registered in done_q
// when the held finish command runs, with match_length and overflow valid
// in that cycle. The receiver cannot stall; it must take the beat then.
// Throughput: one query symbol per cycle while not busy, set by the cell
// row's one-column step; other commands block intake until drained and run.
// Reset clears the stored length, every score, the overflow flag and any
// held command; stored reference symbols are left as they were.
module lcs_length_row_buffer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lcs_pkg::CMD_W-1:0] command,
	input  logic [lcs_pkg::IN_W-1:0]  symbol,
	output logic                      busy,
	output logic                      done,
	output logic [lcs_pkg::LEN_W-1:0] match_length,
	output logic                      overflow
);
	import lcs_pkg::*;

	logic                   accept;
	logic                   pending_q;
	command_t               pend_cmd_q;
	logic [SYMBOL_BITS-1:0] pend_sym_q;
	logic                   row_active;
	logic                   exec;
	logic [CNT_W-1:0]       count_q;
	logic                   overflow_flag_q;
	logic                   done_q;
	logic [LEN_W-1:0]       len_q;
	logic                   ovf_q;
	logic [SCORE_W-1:0]     last_score;
	logic [LEN_W-1:0]       sat_len;

	wave_t                  wave [MAX_LEN+1];
	cell_ctrl_t             ctrl [MAX_LEN];
	logic [SCORE_W-1:0]     score [MAX_LEN];
	logic [MAX_LEN-1:0]     wave_valid;
	logic [MAX_LEN-1:0]     is_last;

	assign accept = start && !busy;
	assign busy   = pending_q;

	always_comb begin
		wave[0].valid = accept && (command_t'(command) == CMD_QUERY);
		wave[0].sym   = SYMBOL_BITS'(symbol);
		wave[0].left  = '0;
		wave[0].diag  = '0;
	end

	assign row_active = |wave_valid;
	assign exec       = pending_q && !row_active;

	// non-query beats wait here until the row has drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept && (command_t'(command) != CMD_QUERY)) begin
			pending_q <= 1'b1;
		end else if (exec) begin
			pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_cmd_q <= command_t'(command);
			pend_sym_q <= SYMBOL_BITS'(symbol);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			overflow_flag_q <= 1'b0;
		end else if (exec) begin
			unique case (pend_cmd_q)
				CMD_APPEND: begin
					if (count_q == CNT_W'(MAX_LEN)) begin
						overflow_flag_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				CMD_CLEAR: begin
					count_q         <= '0;
					overflow_flag_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	genvar j;
	generate
		for (j = 0; j < MAX_LEN; j++) begin : g_col
			always_comb begin
				ctrl[j].active = (count_q > CNT_W'(j));
				ctrl[j].load   = exec && (pend_cmd_q == CMD_APPEND)
					&& (count_q == CNT_W'(j));
				ctrl[j].clear  = exec && ((pend_cmd_q == CMD_FINISH)
					|| (pend_cmd_q == CMD_CLEAR));
				ctrl[j].sym    = pend_sym_q;
			end

			assign is_last[j]    = (count_q == CNT_W'(j + 1));
			assign wave_valid[j] = wave[j+1].valid;

			lcs_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl[j]),
				.wave_in  (wave[j]),
				.wave_out (wave[j+1]),
				.score    (score[j])
			);
		end
	endgenerate

	// at most one column is the last stored one, so an and-or pick is enough
	always_comb begin
		last_score = '0;
		for (int k = 0; k < MAX_LEN; k++) begin
			last_score = last_score | (score[k] & {SCORE_W{is_last[k]}});
		end
		if (32'(last_score) > LEN_MAX) begin
			sat_len = LEN_W'(LEN_MAX);
		end else begin
			sat_len = LEN_W'(last_score);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= exec && (pend_cmd_q == CMD_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (exec && (pend_cmd_q == CMD_FINISH)) begin
			len_q <= sat_len;
			ovf_q <= overflow_flag_q;
		end
	end

	assign done         = done_q;
	assign match_length = len_q;
	assign overflow     = ovf_q;

	a_done_after_held: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(pending_q))
		else $error("result beat without a held finish command");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("stored length beyond capacity");

	a_tail_wave: assert property (@(posedge clk) disable iff (!arst_n)
		wave[MAX_LEN].valid |-> (count_q == CNT_W'(MAX_LEN)))
		else $error("query beat left the row while it was not full");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_flag_q |-> (count_q == CNT_W'(MAX_LEN)))
		else $error("overflow set while store has room");

	a_exec_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> !wave_valid[0])
		else $error("query beat entered while a held command ran");

endmodule
